@@ hdl/mcpid_pkg.sv @@
// Shared types, widths and helpers for the multi-channel PID controller.
// No dependencies; compiled first.
`default_nettype none

package mcpid_pkg;

   // Number of controllers; the channel field wraps modulo this count.
   localparam int CHANNELS = 4;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Transaction field widths
   localparam int CHAN_FW  = 2;
   localparam int POS_W    = 16;
   localparam int LIM_W    = 7;
   localparam int GAIN_W   = 16;
   localparam int DUTY_W   = 8;

   // Datapath widths
   localparam int ERR_W    = POS_W + 1;            // target - position
   localparam int INT_W    = 48;                   // integrator, Q8
   localparam int MUL_B_W  = 33;                   // P fits in 33 bits signed
   localparam int PROD_W   = GAIN_W + MUL_B_W;     // 49
   localparam int SUM_W    = INT_W + 2;            // P + I + D + half
   localparam int FRAC_W   = 8;                    // Q8 fraction bits
   localparam int Q_W      = SUM_W - FRAC_W;

   localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
   localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) <<< (FRAC_W - 1);

   typedef struct packed {
      logic signed [INT_W-1:0] integ;
      logic signed [POS_W-1:0] last_pos;
      logic signed [POS_W-1:0] last_tgt;
   } mem_entry_type;

   typedef struct packed {
      logic                rd_en;
      logic [CH_W-1:0]     rd_addr;
      logic                wr_en;
      logic [CH_W-1:0]     wr_addr;
      mem_entry_type       wr_data;
   } mem_req_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_INTEG,
      S_DERIV,
      S_SUM,
      S_DONE
   } state_type;

   // Channel field folded into the controller range.
   function automatic logic [CH_W-1:0] chan_index(input logic [CHAN_FW-1:0] c);
      logic [CHAN_FW:0] v;
      v = {1'b0, c};
      for (int k = 0; k < (1 << CHAN_FW) - 1; k++) begin
         if (int'(v) >= CHANNELS) begin
            v = v - (CHAN_FW+1)'(CHANNELS);
         end
      end
      return CH_W'(v);
   endfunction

endpackage

`default_nettype wire

@@ hdl/mcpid_if.sv @@
// Valid/ready channel interfaces for PID request and response transactions.
// Depends on mcpid_pkg.
`default_nettype none

interface mcpid_req_if
   import mcpid_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic [CHAN_FW-1:0]         channel;
   logic signed [POS_W-1:0]    target;
   logic signed [POS_W-1:0]    position;
   logic [LIM_W-1:0]           duty_limit;
   logic signed [GAIN_W-1:0]   gain_p;
   logic signed [GAIN_W-1:0]   gain_i;
   logic signed [GAIN_W-1:0]   gain_d;

   modport source (
      output valid, channel, target, position, duty_limit, gain_p, gain_i, gain_d,
      input  ready
   );
   modport sink (
      input  valid, channel, target, position, duty_limit, gain_p, gain_i, gain_d,
      output ready
   );
endinterface

interface mcpid_rsp_if
   import mcpid_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic signed [DUTY_W-1:0]   duty;

   modport source (output valid, duty, input ready);
   modport sink   (input valid, duty, output ready);
endinterface

`default_nettype wire

@@ hdl/mcpid_state_mem.sv @@
// Per-channel state store: integrator, last position, last target.
// Registered read; entries read as zero until first written.
// Depends on mcpid_pkg.
`default_nettype none

module mcpid_state_mem
   import mcpid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  mem_req_type   mem_req,
   output mem_entry_type rd_data
);

   mem_entry_type       mem_ff [CHANNELS];
   mem_entry_type       rd_raw_ff;
   logic [CHANNELS-1:0] valid_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_raw_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

`default_nettype wire

@@ hdl/mcpid_mul.sv @@
// Shared signed gain multiplier, 16 x 33 bits, product registered.
// Depends on mcpid_pkg.
`default_nettype none

module mcpid_mul
   import mcpid_pkg::*;
(
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [GAIN_W-1:0]   op_a,
   input  logic signed [MUL_B_W-1:0]  op_b,
   output logic signed [PROD_W-1:0]   prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

@@ hdl/multi_channel_pid_controller.sv @@
// Multi-channel PID controller, top level: sequencer, state store, shared multiplier.
// Depends on mcpid_pkg, mcpid_if, mcpid_state_mem, mcpid_mul.
`default_nettype none

// Each request transaction runs one PID step for the channel it names (folded
// modulo CHANNELS) and returns one response transaction carrying the duty in
// percent, rounded and clamped to +/- duty_limit. A new target on a channel
// clears that channel's integrator and last position before the step. Per-
// channel state lives in a small synchronous store with a registered read, and
// reads as zero after reset. One item is in flight at a time: the state read,
// three products through the single shared multiplier, the P+I+D sum, then
// rounding and clamping all finish before the next request can be taken.
// The result sits in an output register, so the next request is accepted
// while the previous response still waits; a step only stalls in its final
// cycle if the response before it has not yet been taken.

module multi_channel_pid_controller
   import mcpid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   mcpid_req_if.sink     req_chan,
   mcpid_rsp_if.source   rsp_chan
);

   // Sequencer state
   state_type state_ff, state_in;

   // Captured request transaction
   logic [CH_W-1:0]           chan_ff;
   logic signed [POS_W-1:0]   tgt_ff;
   logic signed [POS_W-1:0]   pos_ff;
   logic [LIM_W-1:0]          lim_ff;
   logic signed [GAIN_W-1:0]  kp_ff;
   logic signed [GAIN_W-1:0]  ki_ff;
   logic signed [GAIN_W-1:0]  kd_ff;

   // Working registers
   logic signed [INT_W-1:0]   integ_ff, integ_in;
   logic signed [POS_W-1:0]   lastpos_ff, lastpos_in;
   logic signed [MUL_B_W-1:0] p_ff;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DUTY_W-1:0]  duty_ff, duty_in;

   // Store and multiplier hookup
   mem_req_type               mem_req;
   mem_entry_type             rd_data;
   logic                      mul_en;
   logic signed [GAIN_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   logic                      accept;
   logic signed [ERR_W-1:0]   err;
   logic signed [ERR_W-1:0]   dpos;
   logic signed [PROD_W:0]    integ_sum;
   logic signed [Q_W-1:0]     q;
   logic signed [Q_W-1:0]     lim_pos;
   logic signed [Q_W-1:0]     lim_neg;
   logic                      round_adj;

   mcpid_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   mcpid_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.duty  = duty_ff;

   // Error and position delta, 17 bits so no wrap
   assign err  = ERR_W'(tgt_ff) - ERR_W'(pos_ff);
   assign dpos = ERR_W'(pos_ff) - ERR_W'(lastpos_ff);

   // Integrator update: prod holds Ki*P here, floor divide by 256 is an arithmetic shift
   assign integ_sum = (PROD_W+1)'(integ_ff) + (PROD_W+1)'(prod >>> FRAC_W);

   // Round: sum already has +0.5; truncate toward zero
   assign round_adj = sum_ff[SUM_W-1] && (sum_ff[FRAC_W-1:0] != '0);
   assign q         = $signed(sum_ff[SUM_W-1:FRAC_W]) + $signed({{(Q_W-1){1'b0}}, round_adj});
   assign lim_pos   = $signed({{(Q_W-LIM_W){1'b0}}, lim_ff});
   assign lim_neg   = -lim_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff <= chan_index(req_chan.channel);
         tgt_ff  <= req_chan.target;
         pos_ff  <= req_chan.position;
         lim_ff  <= req_chan.duty_limit;
         kp_ff   <= req_chan.gain_p;
         ki_ff   <= req_chan.gain_i;
         kd_ff   <= req_chan.gain_d;
      end
      if (state_ff == S_INTEG) begin
         p_ff <= prod[MUL_B_W-1:0];
      end
      integ_ff   <= integ_in;
      lastpos_ff <= lastpos_in;
      sum_ff     <= sum_in;
      duty_ff    <= duty_in;
   end

   always_comb begin
      state_in     = state_ff;
      integ_in     = integ_ff;
      lastpos_in   = lastpos_ff;
      sum_in       = sum_ff;
      duty_in      = duty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      mul_en = 1'b0;
      mul_a  = kp_ff;
      mul_b  = MUL_B_W'(err);

      mem_req         = '0;
      mem_req.rd_addr = chan_index(req_chan.channel);
      mem_req.wr_addr = chan_ff;
      mem_req.wr_data = '{integ: integ_ff, last_pos: pos_ff, last_tgt: tgt_ff};

      unique case (state_ff)
         S_IDLE: begin
            mem_req.rd_en = accept;
            if (accept) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            // new target: drop integrator and last position
            if (rd_data.last_tgt != tgt_ff) begin
               integ_in   = '0;
               lastpos_in = '0;
            end else begin
               integ_in   = rd_data.integ;
               lastpos_in = rd_data.last_pos;
            end
            mul_en   = 1'b1;
            mul_a    = kp_ff;
            mul_b    = MUL_B_W'(err);
            state_in = S_INTEG;
         end
         S_INTEG: begin
            // prod = P
            mul_en   = 1'b1;
            mul_a    = ki_ff;
            mul_b    = prod[MUL_B_W-1:0];
            state_in = S_DERIV;
         end
         S_DERIV: begin
            // prod = Ki*P
            if (integ_sum[PROD_W] != integ_sum[INT_W-1] ||
                integ_sum[PROD_W-1:INT_W] != {(PROD_W-INT_W){integ_sum[INT_W-1]}}) begin
               integ_in = integ_sum[PROD_W] ? INT_MIN : INT_MAX;
            end else begin
               integ_in = integ_sum[INT_W-1:0];
            end
            mul_en   = 1'b1;
            mul_a    = kd_ff;
            mul_b    = MUL_B_W'(dpos);
            state_in = S_SUM;
         end
         S_SUM: begin
            // prod = D
            sum_in = SUM_W'(p_ff) + SUM_W'(integ_ff) + SUM_W'(prod) + HALF;
            mem_req.wr_en = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               if (q > lim_pos) begin
                  duty_in = lim_pos[DUTY_W-1:0];
               end else if (q < lim_neg) begin
                  duty_in = lim_neg[DUTY_W-1:0];
               end else begin
                  duty_in = q[DUTY_W-1:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
